### hw/rtl/mpd_pkg.sv
// Shared types and constants of the motor PID drive step block.
package mpd_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 32;
    localparam logic [15:0] PwmFullScaleRst = 16'hFFFF;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_PROP_GAIN       = 3'd0,
        CFG_INTEG_GAIN      = 3'd1,
        CFG_DERIV_GAIN      = 3'd2,
        CFG_INTEG_SUM_MIN   = 3'd3,
        CFG_INTEG_SUM_MAX   = 3'd4,
        CFG_PWM_FULL_SCALE  = 3'd5,
        CFG_TARGET_DISTANCE = 3'd6
    } t_cfg_idx;

    // Current controller configuration
    typedef struct packed {
        logic signed [15:0] prop_gain;
        logic signed [15:0] integ_gain;
        logic signed [15:0] deriv_gain;
        logic signed [31:0] integ_sum_min;
        logic signed [31:0] integ_sum_max;
        logic        [15:0] pwm_full_scale;
        logic        [31:0] target_distance;
    } t_cfg;

    // One control sample
    typedef struct packed {
        logic signed [15:0] setpoint;
        logic signed [15:0] measured_speed;
        logic        [31:0] travelled_count;
        logic               turning_override;
    } t_sample;

    // One drive result
    typedef struct packed {
        logic [15:0] drive_level;
        logic        reverse;
    } t_result;

endpackage

### hw/rtl/mpd_cfg_regs.sv
// Configuration register file of the motor PID drive step block.
module mpd_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mpd_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [mpd_pkg::CfgDataW-1:0]      i_cfg_data,
    output mpd_pkg::t_cfg                     o_cfg
);

    // Reset contents: everything zero except the full scale
    localparam mpd_pkg::t_cfg CfgRst = '{pwm_full_scale: mpd_pkg::PwmFullScaleRst,
                                         default: '0};

    mpd_pkg::t_cfg r_cfg;
    mpd_pkg::t_cfg n_cfg;

    // Decode the write into the addressed register
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (mpd_pkg::t_cfg_idx'(i_cfg_index))
                mpd_pkg::CFG_PROP_GAIN:       n_cfg.prop_gain       = i_cfg_data[15:0];
                mpd_pkg::CFG_INTEG_GAIN:      n_cfg.integ_gain      = i_cfg_data[15:0];
                mpd_pkg::CFG_DERIV_GAIN:      n_cfg.deriv_gain      = i_cfg_data[15:0];
                mpd_pkg::CFG_INTEG_SUM_MIN:   n_cfg.integ_sum_min   = i_cfg_data[31:0];
                mpd_pkg::CFG_INTEG_SUM_MAX:   n_cfg.integ_sum_max   = i_cfg_data[31:0];
                mpd_pkg::CFG_PWM_FULL_SCALE:  n_cfg.pwm_full_scale  = i_cfg_data[15:0];
                mpd_pkg::CFG_TARGET_DISTANCE: n_cfg.target_distance = i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Hold the registers, reset to their defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CfgRst;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/mpd_pid_core.sv
// PID arithmetic, integral clamp, drive saturation and controller state.
module mpd_pid_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mpd_pkg::t_cfg      i_cfg,
    input  mpd_pkg::t_sample   i_sample,
    input  logic               i_advance,
    output mpd_pkg::t_result   o_result,
    output logic               o_active
);

    logic signed [31:0] r_integ_sum;
    logic signed [17:0] r_last_error;
    logic               r_dir_reverse;

    logic signed [31:0] n_integ_sum;
    logic               n_dir_reverse;

    logic signed [16:0] sp_ext;
    logic signed [16:0] sp_abs;
    logic signed [17:0] err;
    logic signed [18:0] derr;
    logic signed [33:0] prod_p;
    logic signed [47:0] prod_i;
    logic signed [34:0] prod_d;
    logic signed [49:0] pid_sum;
    logic signed [49:0] full_ext;
    logic signed [32:0] integ_new;
    logic               update;

    // Enable control below the target distance or while turning
    assign o_active = (i_sample.travelled_count < i_cfg.target_distance)
                    || i_sample.turning_override;
    assign update   = i_advance && o_active;

    // Take the direction from the setpoint sign, keep it at zero
    always_comb begin
        n_dir_reverse = r_dir_reverse;
        if (i_sample.setpoint > 16'sd0) begin
            n_dir_reverse = 1'b0;
        end else if (i_sample.setpoint < 16'sd0) begin
            n_dir_reverse = 1'b1;
        end
    end

    // Form the error and its change
    assign sp_ext = 17'(i_sample.setpoint);
    assign sp_abs = sp_ext[16] ? -sp_ext : sp_ext;
    assign err    = 18'(sp_abs) - 18'(i_sample.measured_speed);
    assign derr   = 19'(err) - 19'(r_last_error);

    // Three gain products and their full-width sum
    assign prod_p  = 34'(i_cfg.prop_gain)  * 34'(err);
    assign prod_i  = 48'(i_cfg.integ_gain) * 48'(r_integ_sum);
    assign prod_d  = 35'(i_cfg.deriv_gain) * 35'(derr);
    assign pid_sum = 50'(prod_p) + 50'(prod_i) + 50'(prod_d);

    // Accumulate and clamp the integral, min checked first
    assign integ_new = 33'(r_integ_sum) + 33'(err);
    always_comb begin
        if (integ_new < 33'(i_cfg.integ_sum_min)) begin
            n_integ_sum = i_cfg.integ_sum_min;
        end else if (integ_new > 33'(i_cfg.integ_sum_max)) begin
            n_integ_sum = i_cfg.integ_sum_max;
        end else begin
            n_integ_sum = integ_new[31:0];
        end
    end

    // Saturate the drive to zero .. full scale, zero while inactive
    assign full_ext = 50'($signed({1'b0, i_cfg.pwm_full_scale}));
    always_comb begin
        o_result.reverse = o_active ? n_dir_reverse : r_dir_reverse;
        if (!o_active || pid_sum < 50'sd0) begin
            o_result.drive_level = '0;
        end else if (pid_sum > full_ext) begin
            o_result.drive_level = i_cfg.pwm_full_scale;
        end else begin
            o_result.drive_level = pid_sum[15:0];
        end
    end

    // Advance the controller state on each active transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ_sum   <= '0;
            r_last_error  <= '0;
            r_dir_reverse <= 1'b0;
        end else if (update) begin
            r_integ_sum   <= n_integ_sum;
            r_last_error  <= err;
            r_dir_reverse <= n_dir_reverse;
        end
    end

    a_integ_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        update |=> (r_integ_sum >= $past(i_cfg.integ_sum_min)
                    || r_integ_sum == $past(i_cfg.integ_sum_max)))
        else $error("integral left its clamp range");

    a_state_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !update |=> ($stable(r_integ_sum) && $stable(r_last_error)
                     && $stable(r_dir_reverse)))
        else $error("controller state changed without an active transfer");

    a_last_error_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        update |=> (r_last_error == $past(err)))
        else $error("previous error not captured");

endmodule

### hw/rtl/motor_pid_drive_step_top.sv
// Top level of the motor PID drive step block: sample and result registers.
//
// One control sample per clock while the result is not stalled: a sample is
// registered on transfer, the PID sum, integral clamp and drive saturation
// are worked out from the sample register and the result is captured in the
// result register as the sample moves on, so a new sample may follow every
// cycle. A stalled result holds the sample register and stalls the input
// until it leaves. The integral, previous error and direction are updated at
// that same edge, so each sample sees the state left by the one before it.
// Samples at or past the target distance without the turning flag give a zero
// drive and leave the state untouched. Configuration writes take effect at
// the next edge and belong to idle periods.
module motor_pid_drive_step_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [mpd_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [mpd_pkg::CfgDataW-1:0]  i_cfg_data,
    // sample channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [15:0]            i_setpoint,
    input  logic signed [15:0]            i_measured_speed,
    input  logic        [31:0]            i_travelled_count,
    input  logic                          i_turning_override,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic        [15:0]            o_drive_level,
    output logic                          o_reverse
);

    mpd_pkg::t_cfg    cfg;
    mpd_pkg::t_sample r_sample;
    mpd_pkg::t_result r_result;
    mpd_pkg::t_result result;
    logic             r_in_vld;
    logic             r_out_vld;
    logic             advance;
    logic             active;
    logic             in_xfer;

    mpd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mpd_pid_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_sample  (r_sample),
        .i_advance (advance),
        .o_result  (result),
        .o_active  (active)
    );

    // Move the held sample on unless the result register is blocked
    assign advance    = r_in_vld && !(r_out_vld && i_out_stall);
    assign o_in_stall = r_in_vld && r_out_vld && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Valid flags of the two registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (!(r_out_vld && i_out_stall)) begin
                r_out_vld <= advance;
            end
        end
    end

    // Capture the sample on transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_sample.setpoint         <= i_setpoint;
            r_sample.measured_speed   <= i_measured_speed;
            r_sample.travelled_count  <= i_travelled_count;
            r_sample.turning_override <= i_turning_override;
        end
    end

    // Capture the result as the sample moves on
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_drive_level = r_result.drive_level;
    assign o_reverse     = r_result.reverse;

    a_idle_zero_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !active) |=> (o_out_valid && o_drive_level == 16'd0))
        else $error("inactive sample produced a drive");

    a_sample_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && o_in_stall) |=> (r_in_vld && $stable(r_sample)))
        else $error("blocked sample lost or changed");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("sample moved on without a result");

endmodule
